>>> design/tun_pkg.sv
`default_nettype none
package tun_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int OUT_FRAC_BITS = 30;

  localparam int CW    = COORD_WIDTH;
  localparam int F     = OUT_FRAC_BITS;
  localparam int DW    = CW + 1;
  localparam int LOW   = DW / 2;
  localparam int HIW   = DW - LOW;
  localparam int PW    = 2 * DW;
  localparam int NW    = PW + 1;
  localparam int MAGW  = PW;
  localparam int LW    = (MAGW + 2) / 3;
  localparam int NSQW  = 2 * MAGW;
  localparam int SW    = NSQW + 2;
  localparam int XW    = SW + 2 * F + 2;
  localparam int MW    = F + 1;
  localparam int OW    = F + 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [NW-1:0] cross_t;
  typedef logic signed [OW-1:0] comp_t;

  typedef struct packed {
    logic [XW-1:0] rem;
    logic [XW-1:0] acc_t;
    logic [MW-1:0] mag;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic [XW-1:0] sb;
    logic [SW-1:0] s;
    logic          deg;
    lane_t [2:0]   lane;
  } cell_t;

endpackage
`default_nettype wire

>>> design/triangle_unit_normal_top.sv
`default_nettype none
// Channel   Handshake               Payload
// in_       in_valid / in_stall     in_point_{a,b,c}_{x,y,z}, Q16.16 signed
// out_      out_valid / out_stall   out_normal_{x,y,z} Q2.30 signed, out_degenerate
//
// One item per cycle unless a waiting result is stalled. Stages in order: cross
// product, squaring and summing, one digit cell per quotient bit, one rounding
// stage.
// Reset clears the valid bits of every stage; the pipeline is empty after reset.
// A stalled result holds the whole pipeline; in_stall follows out_stall while a
// result is waiting.
module triangle_unit_normal_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [tun_pkg::CW-1:0] in_point_a_x,
  input  logic signed [tun_pkg::CW-1:0] in_point_a_y,
  input  logic signed [tun_pkg::CW-1:0] in_point_a_z,
  input  logic signed [tun_pkg::CW-1:0] in_point_b_x,
  input  logic signed [tun_pkg::CW-1:0] in_point_b_y,
  input  logic signed [tun_pkg::CW-1:0] in_point_b_z,
  input  logic signed [tun_pkg::CW-1:0] in_point_c_x,
  input  logic signed [tun_pkg::CW-1:0] in_point_c_y,
  input  logic signed [tun_pkg::CW-1:0] in_point_c_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [tun_pkg::OW-1:0] out_normal_x,
  output logic signed [tun_pkg::OW-1:0] out_normal_y,
  output logic signed [tun_pkg::OW-1:0] out_normal_z,
  output logic                        out_degenerate
);
  import tun_pkg::*;

  logic   en;
  coord_t pa [3];
  coord_t pb [3];
  coord_t pc [3];
  logic   cross_vld;
  cross_t n  [3];
  cell_t  chain     [F+2];
  logic   chain_vld [F+2];
  comp_t  nrm [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign pa[0] = in_point_a_x;
  assign pa[1] = in_point_a_y;
  assign pa[2] = in_point_a_z;
  assign pb[0] = in_point_b_x;
  assign pb[1] = in_point_b_y;
  assign pb[2] = in_point_b_z;
  assign pc[0] = in_point_c_x;
  assign pc[1] = in_point_c_y;
  assign pc[2] = in_point_c_z;

  tun_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_valid),
    .pa_i  (pa),
    .pb_i  (pb),
    .pc_i  (pc),
    .vld_o (cross_vld),
    .n_o   (n)
  );

  tun_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cross_vld),
    .n_i    (n),
    .vld_o  (chain_vld[0]),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g <= F; g++) begin : g_cell
    tun_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (chain_vld[g]),
      .cell_i (chain[g]),
      .vld_o  (chain_vld[g+1]),
      .cell_o (chain[g+1])
    );
  end

  tun_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (chain_vld[F+1]),
    .cell_i (chain[F+1]),
    .vld_o  (out_valid),
    .nrm_o  (nrm),
    .deg_o  (out_degenerate)
  );

  assign out_normal_x = nrm[0];
  assign out_normal_y = nrm[1];
  assign out_normal_z = nrm[2];

endmodule
`default_nettype wire

>>> design/tun_cross.sv
`default_nettype none
module tun_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  tun_pkg::coord_t pa_i [3],
  input  tun_pkg::coord_t pb_i [3],
  input  tun_pkg::coord_t pc_i [3],
  output logic            vld_o,
  output tun_pkg::cross_t n_o  [3]
);
  import tun_pkg::*;

  diff_t p1_r [3];
  diff_t p2_r [3];
  logic  v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= DW'(pa_i[i]) - DW'(pb_i[i]);
        p2_r[i] <= DW'(pb_i[i]) - DW'(pc_i[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [HIW-1:0]    qh0, qh1;
    logic signed [LOW:0]      ql0, ql1;
    logic signed [DW+HIW-1:0] hi0_r, hi1_r;
    logic signed [DW+LOW:0]   lo0_r, lo1_r;
    cross_t                   n_r;

    assign qh0 = $signed(p2_r[K][DW-1:LOW]);
    assign ql0 = $signed({1'b0, p2_r[K][LOW-1:0]});
    assign qh1 = $signed(p2_r[J][DW-1:LOW]);
    assign ql1 = $signed({1'b0, p2_r[J][LOW-1:0]});

    always_ff @(posedge clk) begin
      if (en) begin
        hi0_r <= p1_r[J] * qh0;
        lo0_r <= p1_r[J] * ql0;
        hi1_r <= p1_r[K] * qh1;
        lo1_r <= p1_r[K] * ql1;
        n_r   <= (NW'(hi0_r) <<< LOW) + NW'(lo0_r) - (NW'(hi1_r) <<< LOW) - NW'(lo1_r);
      end
    end

    assign n_o[i] = n_r;
  end

  assign vld_o = v3_r;

endmodule
`default_nettype wire

>>> design/tun_norm.sv
`default_nettype none
module tun_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  tun_pkg::cross_t n_i [3],
  output logic            vld_o,
  output tun_pkg::cell_t  cell_o
);
  import tun_pkg::*;

  localparam int QW = 6 * LW + 2;

  logic            va_r, vb_r, vc_r, vd_r;
  logic [NSQW-1:0] nsq [3];
  logic            neg [3];
  logic [SW-1:0]   s_sum;
  cell_t           cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_i;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [MAGW-1:0]  mag_r;
    logic             neg_a_r, neg_b_r, neg_c_r;
    logic [3*LW-1:0]  magp;
    logic [LW-1:0]    l0, l1, l2;
    logic [2*LW-1:0]  pp_r [6];
    logic [QW-1:0]    q;
    logic [NSQW-1:0]  nsq_r;

    assign magp = (3*LW)'(mag_r);
    assign l0   = magp[LW-1:0];
    assign l1   = magp[2*LW-1:LW];
    assign l2   = magp[3*LW-1:2*LW];

    assign q = QW'(pp_r[0])
             + (QW'(pp_r[1]) << (2*LW))
             + (QW'(pp_r[2]) << (4*LW))
             + (QW'(pp_r[3]) << (LW+1))
             + (QW'(pp_r[4]) << (2*LW+1))
             + (QW'(pp_r[5]) << (3*LW+1));

    always_ff @(posedge clk) begin
      if (en) begin
        neg_a_r <= n_i[i][NW-1];
        mag_r   <= MAGW'(n_i[i][NW-1] ? -n_i[i] : n_i[i]);
        neg_b_r <= neg_a_r;
        pp_r[0] <= l0 * l0;
        pp_r[1] <= l1 * l1;
        pp_r[2] <= l2 * l2;
        pp_r[3] <= l0 * l1;
        pp_r[4] <= l0 * l2;
        pp_r[5] <= l1 * l2;
        neg_c_r <= neg_b_r;
        nsq_r   <= NSQW'(q);
      end
    end

    assign nsq[i] = nsq_r;
    assign neg[i] = neg_c_r;
  end

  assign s_sum = SW'(nsq[0]) + SW'(nsq[1]) + SW'(nsq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.sb  <= XW'(s_sum) << (2*F);
      cell_r.s   <= s_sum;
      cell_r.deg <= (s_sum == '0);
      for (int i = 0; i < 3; i++) begin
        cell_r.lane[i].rem   <= XW'(nsq[i]) << (2*F);
        cell_r.lane[i].acc_t <= '0;
        cell_r.lane[i].mag   <= '0;
        cell_r.lane[i].neg   <= neg[i];
      end
    end
  end

  assign vld_o  = vd_r;
  assign cell_o = cell_r;

endmodule
`default_nettype wire

>>> design/tun_cell.sv
`default_nettype none
module tun_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  tun_pkg::cell_t cell_i,
  output logic           vld_o,
  output tun_pkg::cell_t cell_o
);
  import tun_pkg::*;

  logic [XW-1:0] d    [3];
  logic          take [3];
  cell_t         cell_nxt;
  cell_t         cell_r;
  logic          vld_r;

  always_comb begin
    cell_nxt     = cell_i;
    cell_nxt.sb  = cell_i.sb >> 2;
    for (int i = 0; i < 3; i++) begin
      d[i]    = cell_i.lane[i].acc_t + cell_i.sb;
      take[i] = (cell_i.lane[i].rem >= d[i]);
      cell_nxt.lane[i].rem   = take[i] ? cell_i.lane[i].rem - d[i] : cell_i.lane[i].rem;
      cell_nxt.lane[i].acc_t = (cell_i.lane[i].acc_t >> 1) + (take[i] ? cell_i.sb : '0);
      cell_nxt.lane[i].mag   = {cell_i.lane[i].mag[MW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign cell_o = cell_r;

endmodule
`default_nettype wire

>>> design/tun_round.sv
`default_nettype none
module tun_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  tun_pkg::cell_t cell_i,
  output logic           vld_o,
  output tun_pkg::comp_t nrm_o [3],
  output logic           deg_o
);
  import tun_pkg::*;

  logic [XW+1:0] lhs  [3];
  logic [XW+1:0] rhs  [3];
  logic [MW-1:0] m    [3];
  comp_t         val  [3];
  comp_t         nrm_nxt [3];
  comp_t         nrm_r [3];
  logic          deg_r;
  logic          vld_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lhs[i] = {cell_i.lane[i].rem, 2'b00};
      rhs[i] = {cell_i.lane[i].acc_t, 2'b00} + (XW+2)'(cell_i.s);
      m[i]   = cell_i.lane[i].mag + MW'(lhs[i] >= rhs[i]);
      val[i] = OW'(m[i]);
      nrm_nxt[i] = cell_i.deg ? '0 : (cell_i.lane[i].neg ? -val[i] : val[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_r <= nrm_nxt;
      deg_r <= cell_i.deg;
    end
  end

  assign vld_o = vld_r;
  assign nrm_o = nrm_r;
  assign deg_o = deg_r;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
  import tun_pkg::*;

  localparam int MAX_CYCLES = 400000;

  typedef struct {
    logic signed [OW-1:0] nx;
    logic signed [OW-1:0] ny;
    logic signed [OW-1:0] nz;
    logic                 deg;
  } normal_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  logic out_valid;
  logic out_stall;
  logic signed [OW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_degenerate;

  normal_t normals_due[$];
  int mismatches = 0;
  int cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int burst_left = 0;

  triangle_unit_normal_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_a_x(ax), .in_point_a_y(ay), .in_point_a_z(az),
    .in_point_b_x(bx), .in_point_b_y(by), .in_point_b_z(bz),
    .in_point_c_x(cx), .in_point_c_y(cy), .in_point_c_z(cz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z), .out_degenerate(out_degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // rounded |n| * 2^F / sqrt(s), signed code
  function automatic logic signed [OW-1:0] unit_part(logic signed [127:0] n,
                                                      logic [255:0] s);
    logic [255:0] mag, lim, cand, prod;
    logic [63:0] m;
    mag = n[127] ? 256'(-n) : 256'(n);
    lim = (mag * mag) << (2 * F);
    m = 0;
    for (int b = F; b >= 0; b--) begin
      cand = 256'(m | (64'd1 << b));
      prod = cand * cand * s;
      if (prod <= lim) m = m | (64'd1 << b);
    end
    cand = 256'(2 * m + 1);
    prod = cand * cand * s;
    if (prod <= (lim << 2)) m = m + 1;
    return n[127] ? OW'(-m) : OW'(m);
  endfunction

  function automatic normal_t triangle_normal(coord_t pax, coord_t pay, coord_t paz,
                                              coord_t pbx, coord_t pby, coord_t pbz,
                                              coord_t pcx, coord_t pcy, coord_t pcz);
    logic signed [127:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [255:0] s;
    normal_t r;
    ux = 128'(longint'(pax) - longint'(pbx));
    uy = 128'(longint'(pay) - longint'(pby));
    uz = 128'(longint'(paz) - longint'(pbz));
    vx = 128'(longint'(pbx) - longint'(pcx));
    vy = 128'(longint'(pby) - longint'(pcy));
    vz = 128'(longint'(pbz) - longint'(pcz));
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    s = 256'(nx) * 256'(nx) + 256'(ny) * 256'(ny) + 256'(nz) * 256'(nz);
    if (s == 0) begin
      r = '{0, 0, 0, 1'b1};
    end else begin
      r.nx = unit_part(nx, s);
      r.ny = unit_part(ny, s);
      r.nz = unit_part(nz, s);
      r.deg = 1'b0;
    end
    return r;
  endfunction

  task automatic send_triangle(coord_t pax, coord_t pay, coord_t paz,
                               coord_t pbx, coord_t pby, coord_t pbz,
                               coord_t pcx, coord_t pcy, coord_t pcz);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    {ax, ay, az, bx, by, bz, cx, cy, cz} = {pax, pay, paz, pbx, pby, pbz, pcx, pcy, pcz};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    normals_due.push_back(triangle_normal(pax, pay, paz, pbx, pby, pbz, pcx, pcy, pcz));
    @(negedge clk);
  endtask

  // hold valid low once the stream pauses
  task automatic idle_input();
    in_valid = 1'b0;
    burst_left = 0;
  endtask

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return coord_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    mx = 32'sh7FFFFFFF;
    mn = 32'sh80000000;
    send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_triangle(5, 6, 7, 5, 6, 7, 5, 6, 7);
    send_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2);
    send_triangle(mn, mn, mn, mx, mx, mx, mn, mn, mn);
    send_triangle(0, 0, 0, 65536, 0, 0, 0, 65536, 0);
    send_triangle(0, 0, 0, 0, 65536, 0, 0, 0, 65536);
    send_triangle(0, 0, 0, 0, 0, 65536, 65536, 0, 0);
    send_triangle(0, 0, 0, 0, 65536, 0, 65536, 0, 0);
    send_triangle(mx, 0, 0, mn, 0, 0, 0, mx, 0);
    send_triangle(mn, mn, 0, mx, mn, 0, mn, mx, mx);
    send_triangle(mx, mx, mx, mn, mx, mn, mx, mn, mn);
    send_triangle(mn, mx, mn, mx, mn, mx, 0, 0, mn);
    send_triangle(1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_triangle(1, 2, 3, 4, 5, 6, 7, 8, 10);
    send_triangle(mx, mx, mx, mn, mn, mn, 0, 1, 0);
    send_triangle(-1, -1, -1, 0, 0, 0, 1, 0, 0);
    send_triangle(0, 0, 0, 3, 4, 0, 3, 4, 1);
    send_triangle(0, 0, 0, 1, 1, 0, 2, 1, 0);
    idle_input();
  endtask

  task automatic test_random(int count);
    coord_t p[9];
    int kind, sc;
    repeat (count) begin
      kind = $urandom_range(0, 2);
      foreach (p[i]) p[i] = rand_coord(kind);
      if ($urandom_range(0, 9) == 0) begin
        // collinear: C lies on the line through A and B
        sc = $urandom_range(0, 4) - 2;
        for (int i = 0; i < 3; i++) begin
          p[i] = rand_coord(1);
          p[3 + i] = rand_coord(1);
          p[6 + i] = p[3 + i] + coord_t'(sc) * (p[3 + i] - p[i]);
        end
      end else if ($urandom_range(0, 29) == 0) begin
        for (int i = 0; i < 3; i++) p[6 + i] = p[3 + i];
      end
      send_triangle(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
    end
    idle_input();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 200);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (cycles % 5 < 2);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = normals_due.pop_front();
        if (out_normal_x !== want.nx || out_normal_y !== want.ny ||
            out_normal_z !== want.nz || out_degenerate !== want.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                     want.nx, want.ny, want.nz, want.deg,
                     out_normal_x, out_normal_y, out_normal_z, out_degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(1450);
    while (normals_due.size() != 0) @(negedge clk);
    repeat (3 * (8 + F + 1)) @(negedge clk);
    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
